// ===== rtl/core/ldbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbs_pkg: shared types and constants for the two-wire byte serialiser
// Register indexes, field widths and the queued request entry.
// ----------------------------------------------------------------------------
package ldbs_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned BRIGHT_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned FIFO_DEPTH_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CMD_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON = 2'd2;

	localparam logic [BYTE_W-1:0] CMD_BASE_RST   = 8'h80;
	localparam logic [BRIGHT_W-1:0] BRIGHT_RST   = 3'd7;
	localparam logic              DISP_ON_RST    = 1'b1;
	localparam logic [BYTE_W-1:0] DISP_ON_MASK   = 8'h08;

	localparam logic REQ_DATA    = 1'b0;
	localparam logic REQ_CONTROL = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              begin_txn;
		logic              end_txn;
	} ldbs_entry_t;

endpackage

// ===== rtl/core/ldbs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbs_if: channel interfaces of the two-wire byte serialiser
// Request, pin phase and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface ldbs_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic       begin_txn;
	logic       end_txn;

	modport source (output valid, req_type, data_byte, begin_txn, end_txn, input ready);
	modport sink   (input valid, req_type, data_byte, begin_txn, end_txn, output ready);
endinterface

interface ldbs_phase_if;
	logic valid;
	logic ready;
	logic clk_high;
	logic dio_high;
	logic last_phase;

	modport source (output valid, clk_high, dio_high, last_phase, input ready);
	modport sink   (input valid, clk_high, dio_high, last_phase, output ready);
endinterface

interface ldbs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ldbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbs_front: request intake and configuration registers
// Resolves each request to the byte to send and pushes it to the queue.
// ----------------------------------------------------------------------------
module ldbs_front
	import ldbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ldbs_req_if.sink    req,
	ldbs_cfg_if.sink    cfg,
	output logic        push_valid,
	input  logic        push_ready,
	output ldbs_entry_t push_entry
);

	logic [BYTE_W-1:0]   cmd_base_q;
	logic [BRIGHT_W-1:0] brightness_q;
	logic                display_on_q;
	logic [BYTE_W-1:0]   ctrl_byte;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_base_q   <= CMD_BASE_RST;
			brightness_q <= BRIGHT_RST;
			display_on_q <= DISP_ON_RST;
		end else if (cfg.valid) begin
			// indexes past the list drop the write
			unique case (cfg.index)
				CFG_CMD_BASE:   cmd_base_q   <= cfg.data;
				CFG_BRIGHTNESS: brightness_q <= cfg.data[BRIGHT_W-1:0];
				CFG_DISPLAY_ON: display_on_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign ctrl_byte = cmd_base_q
		| (display_on_q ? DISP_ON_MASK : '0)
		| {{(BYTE_W-BRIGHT_W){1'b0}}, brightness_q};

	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	always_comb begin
		push_entry.tx_byte   = (req.req_type == REQ_CONTROL) ? ctrl_byte : req.data_byte;
		push_entry.begin_txn = req.begin_txn;
		push_entry.end_txn   = req.end_txn;
	end

endmodule

// ===== rtl/core/ldbs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbs_fifo: short request queue
// Decouples request intake from the phase sequencer.
// ----------------------------------------------------------------------------
module ldbs_fifo
	import ldbs_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  ldbs_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop_ready,
	output ldbs_entry_t pop_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ldbs_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ldbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbs_back: pin phase sequencer
// Walks optional start, eight bit slots, acknowledge and optional stop, one phase per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ldbs_back
	import ldbs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  ldbs_entry_t  pop_entry,
	ldbs_phase_if.source phase
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_BIT,
		PH_ACK,
		PH_STOP
	} ph_t;

	ph_t               ph_q;
	logic [1:0]        sub_q;
	logic [2:0]        bit_q;
	logic [BYTE_W-1:0] byte_q;
	logic              end_q;

	logic out_valid_q;
	logic clk_high_q;
	logic dio_high_q;
	logic last_q;

	ph_t               cur_ph;
	logic [1:0]        cur_sub;
	logic [2:0]        cur_bit;
	logic [BYTE_W-1:0] cur_byte;
	logic              cur_end;
	logic              active;
	logic              advance;

	ph_t               nxt_ph;
	logic [1:0]        nxt_sub;
	logic [2:0]        nxt_bit;
	logic [BYTE_W-1:0] nxt_byte;
	logic              ph_clk;
	logic              ph_dio;
	logic              ph_last;

	// when idle, start straight from the queue head so items run back to back
	always_comb begin
		if (ph_q == PH_IDLE) begin
			cur_ph   = pop_entry.begin_txn ? PH_START : PH_BIT;
			cur_sub  = 2'd0;
			cur_bit  = 3'd0;
			cur_byte = pop_entry.tx_byte;
			cur_end  = pop_entry.end_txn;
		end else begin
			cur_ph   = ph_q;
			cur_sub  = sub_q;
			cur_bit  = bit_q;
			cur_byte = byte_q;
			cur_end  = end_q;
		end
	end

	assign active    = (ph_q != PH_IDLE) || pop_valid;
	assign advance   = active && (!out_valid_q || phase.ready);
	assign pop_ready = (ph_q == PH_IDLE) && advance;

	always_comb begin
		nxt_ph   = cur_ph;
		nxt_sub  = cur_sub + 2'd1;
		nxt_bit  = cur_bit;
		nxt_byte = cur_byte;
		ph_clk   = 1'b0;
		ph_dio   = 1'b0;
		ph_last  = 1'b0;
		unique case (cur_ph)
			PH_START: begin
				ph_clk  = 1'b1;
				ph_dio  = 1'b0;
				nxt_ph  = PH_BIT;
				nxt_sub = 2'd0;
			end
			PH_BIT: begin
				ph_clk = (cur_sub == 2'd2);
				ph_dio = (cur_sub == 2'd0) ? 1'b1 : cur_byte[0];
				if (cur_sub == 2'd2) begin
					nxt_sub  = 2'd0;
					nxt_byte = cur_byte >> 1;
					nxt_bit  = cur_bit + 3'd1;
					if (cur_bit == 3'd7) begin
						nxt_ph = PH_ACK;
					end
				end
			end
			PH_ACK: begin
				ph_clk = (cur_sub == 2'd1);
				ph_dio = (cur_sub != 2'd2);
				if (cur_sub == 2'd2) begin
					nxt_sub = 2'd0;
					nxt_ph  = cur_end ? PH_STOP : PH_IDLE;
					ph_last = !cur_end;
				end
			end
			PH_STOP: begin
				ph_clk = (cur_sub != 2'd0);
				ph_dio = (cur_sub == 2'd2);
				if (cur_sub == 2'd2) begin
					nxt_sub = 2'd0;
					nxt_ph  = PH_IDLE;
					ph_last = 1'b1;
				end
			end
			default: begin
				nxt_ph = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			sub_q       <= '0;
			bit_q       <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ph_q        <= nxt_ph;
				sub_q       <= nxt_sub;
				bit_q       <= nxt_bit;
				end_q       <= cur_end;
				out_valid_q <= 1'b1;
			end else if (phase.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q     <= nxt_byte;
			clk_high_q <= ph_clk;
			dio_high_q <= ph_dio;
			last_q     <= ph_last;
		end
	end

	assign phase.valid      = out_valid_q;
	assign phase.clk_high   = clk_high_q;
	assign phase.dio_high   = dio_high_q;
	assign phase.last_phase = last_q;

endmodule

// ===== rtl/core/led_driver_two_wire_byte_serializer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_driver_two_wire_byte_serializer_top: two-wire display byte writer
// Turns byte and control-command requests into open-drain pin phases.
// ----------------------------------------------------------------------------
// channel  dir  payload                                   request
// req      in   req_type, data_byte, begin_txn, end_txn   one byte to send
// phase    out  clk_high, dio_high, last_phase            one pin phase
// cfg      in   index, data                               one register write
//
// Each request takes 27 to 31 pin phases: the phase sequencer emits one pin phase
// per cycle unless the output stalls, 24 for the byte, 3 for the acknowledge, plus start and stop.
// The queue takes further requests while the sequencer is still busy.
// A stalled phase holds in the output register; the sequencer waits on it.
// Reset clears the queue and sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module led_driver_two_wire_byte_serializer_top
	import ldbs_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ldbs_req_if.sink     req,
	ldbs_phase_if.source phase,
	ldbs_cfg_if.sink     cfg
);

	logic        push_valid;
	logic        push_ready;
	ldbs_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	ldbs_entry_t pop_entry;

	ldbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ldbs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	ldbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.phase     (phase)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-wire display byte serialiser
// A scripted table of requests and register writes comes first, followed by
// random transactions under several register settings and idling mixes.
// Every pin phase is checked in order against phases predicted per request.
// ----------------------------------------------------------------------------
module tb_top
	import ldbs_pkg::*;
;

	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int unsigned RAND_PHASES = 5;
	localparam int unsigned ITEMS_PER_PHASE = 52;
	localparam int unsigned LONG_HOLD = 300;

	typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       begin_txn;
		logic       end_txn;
	} byte_req_t;

	typedef struct packed {
		logic clk_high;
		logic dio_high;
		logic last_phase;
	} pin_phase_t;

	typedef struct packed {
		row_kind_t             kind;
		byte_req_t             rq;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		logic                  typed;
		logic [BYTE_W-1:0]     wire_byte;
	} script_row_t;

	// typed rows give the byte expected on the wire
	script_row_t script [0:24] = '{
		'{ROW_REQ, '{REQ_CONTROL, 8'h00, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h8F},
		'{ROW_REQ, '{REQ_DATA,    8'h00, 1'b1, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h00},
		'{ROW_REQ, '{REQ_DATA,    8'hFF, 1'b0, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b1, 8'hFF},
		'{ROW_REQ, '{REQ_DATA,    8'hA5, 1'b0, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'hA5},
		'{ROW_REQ, '{REQ_DATA,    8'h5A, 1'b0, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h5A},
		'{ROW_REQ, '{REQ_DATA,    8'h01, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h01},
		'{ROW_REQ, '{REQ_DATA,    8'h80, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h80},
		'{ROW_REQ, '{REQ_CONTROL, 8'hFF, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h8F},
		'{ROW_REQ, '{REQ_CONTROL, 8'h55, 1'b0, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h8F},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_CMD_BASE,   8'h00, 1'b0, 8'h00},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_BRIGHTNESS, 8'h00, 1'b0, 8'h00},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_DISPLAY_ON, 8'h00, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'hC3, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h00},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_CMD_BASE,   8'hFF, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'h00, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'hFF},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_CMD_BASE,   8'h40, 1'b0, 8'h00},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_BRIGHTNESS, 8'hFD, 1'b0, 8'h00},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_DISPLAY_ON, 8'hFE, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'h00, 1'b1, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h45},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_UNMAPPED,   8'hFF, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'h00, 1'b0, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h45},
		'{ROW_CFG, '{REQ_DATA,    8'h00, 1'b0, 1'b0}, CFG_DISPLAY_ON, 8'h03, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'h00, 1'b1, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b1, 8'h4D},
		'{ROW_REQ, '{REQ_DATA,    8'h3C, 1'b1, 1'b0}, CFG_CMD_BASE, 8'h00, 1'b0, 8'h00},
		'{ROW_REQ, '{REQ_CONTROL, 8'h96, 1'b0, 1'b1}, CFG_CMD_BASE, 8'h00, 1'b0, 8'h00}
	};

	logic clk;
	logic arst_n;

	ldbs_req_if   req_ch ();
	ldbs_phase_if phase_ch ();
	ldbs_cfg_if   cfg_ch ();

	led_driver_two_wire_byte_serializer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.phase  (phase_ch),
		.cfg    (cfg_ch)
	);

	// register copies held by the predictor
	logic [BYTE_W-1:0]   cmd_base;
	logic [BRIGHT_W-1:0] bright;
	logic                disp_on;

	pin_phase_t pin_phase_q [$];

	int unsigned error_count;
	int unsigned phases_seen;
	int unsigned reqs_sent;
	int unsigned reg_writes;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	logic        rx_hold;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] control_byte();
		return cmd_base | (disp_on ? DISP_ON_MASK : 8'h00) | {5'b0, bright};
	endfunction

	function automatic logic [BYTE_W-1:0] wire_byte_of(byte_req_t rq);
		return (rq.req_type == REQ_CONTROL) ? control_byte() : rq.data_byte;
	endfunction

	function automatic void add_phase(ref pin_phase_t seq [$], input logic c, input logic d);
		pin_phase_t p;
		p.clk_high = c;
		p.dio_high = d;
		p.last_phase = 1'b0;
		seq.push_back(p);
	endfunction

	// optional start, eight bits lsb first, acknowledge slot, optional stop
	function automatic void queue_pin_phases(logic [BYTE_W-1:0] wb, logic bgn, logic fin);
		pin_phase_t seq [$];
		pin_phase_t p;
		logic [BYTE_W-1:0] sh;
		sh = wb;
		if (bgn)
			add_phase(seq, 1'b1, 1'b0);
		for (int i = 0; i < BYTE_W; i++) begin
			add_phase(seq, 1'b0, 1'b1);
			add_phase(seq, 1'b0, sh[0]);
			add_phase(seq, 1'b1, sh[0]);
			sh = sh >> 1;
		end
		add_phase(seq, 1'b0, 1'b1);
		add_phase(seq, 1'b1, 1'b1);
		add_phase(seq, 1'b0, 1'b0);
		if (fin) begin
			add_phase(seq, 1'b0, 1'b0);
			add_phase(seq, 1'b1, 1'b0);
			add_phase(seq, 1'b1, 1'b1);
		end
		p = seq.pop_back();
		p.last_phase = 1'b1;
		seq.push_back(p);
		foreach (seq[k])
			pin_phase_q.push_back(seq[k]);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_CMD_BASE:   cmd_base = val;
			CFG_BRIGHTNESS: bright = val[BRIGHT_W-1:0];
			CFG_DISPLAY_ON: disp_on = val[0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic want, logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
			error_count++;
		end
	endfunction

	// offer one request, with a random idle gap first; predict on acceptance
	task automatic push_req(byte_req_t rq, logic [BYTE_W-1:0] wb);
		int unsigned gap;
		gap = 0;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rq.req_type;
		req_ch.data_byte <= rq.data_byte;
		req_ch.begin_txn <= rq.begin_txn;
		req_ch.end_txn   <= rq.end_txn;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		queue_pin_phases(wb, rq.begin_txn, rq.end_txn);
		reqs_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, val);
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop the request line and wait for every predicted phase to arrive
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pin_phase_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_request(logic bgn, logic fin, int unsigned ctrl_pct);
		byte_req_t rq;
		rq.req_type  = ($urandom_range(99) < ctrl_pct) ? REQ_CONTROL : REQ_DATA;
		rq.data_byte = 8'($urandom_range(0, 255));
		rq.begin_txn = bgn;
		rq.end_txn   = fin;
		push_req(rq, wire_byte_of(rq));
	endtask

	always @(posedge clk) begin
		if (rx_hold)
			phase_ch.ready <= 1'b0;
		else
			phase_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin : phase_check
		pin_phase_t want;
		if (arst_n && phase_ch.valid && phase_ch.ready) begin
			phases_seen++;
			if (pin_phase_q.size() == 0) begin
				$display("%0t: unexpected phase, expected none, got clk %0b dio %0b last %0b",
					$time, phase_ch.clk_high, phase_ch.dio_high, phase_ch.last_phase);
				error_count++;
			end else begin
				want = pin_phase_q.pop_front();
				check_field("clk_high", want.clk_high, phase_ch.clk_high);
				check_field("dio_high", want.dio_high, phase_ch.dio_high);
				check_field("last_phase", want.last_phase, phase_ch.last_phase);
			end
		end
	end

	initial begin
		byte_req_t rq;
		int unsigned sent;
		int unsigned len;
		error_count = 0;
		phases_seen = 0;
		reqs_sent = 0;
		reg_writes = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 1'b0;
		cmd_base = CMD_BASE_RST;
		bright = BRIGHT_RST;
		disp_on = DISP_ON_RST;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_DATA;
		req_ch.data_byte = '0;
		req_ch.begin_txn = 1'b0;
		req_ch.end_txn = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CMD_BASE;
		cfg_ch.data = '0;
		phase_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG) begin
				settle();
				write_reg(script[r].reg_idx, script[r].reg_data);
			end else begin
				rq = script[r].rq;
				push_req(rq, script[r].typed ? script[r].wire_byte : wire_byte_of(rq));
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				1: begin
					write_reg(CFG_CMD_BASE, 8'hFF);
					write_reg(CFG_BRIGHTNESS, 8'hFF);
					write_reg(CFG_DISPLAY_ON, 8'hFF);
				end
				2: begin
					write_reg(CFG_CMD_BASE, 8'h00);
					write_reg(CFG_BRIGHTNESS, 8'h00);
					write_reg(CFG_DISPLAY_ON, 8'h00);
				end
				default: begin
					write_reg(CFG_CMD_BASE, CFG_DATA_W'($urandom_range(0, 255)));
					write_reg(CFG_BRIGHTNESS, CFG_DATA_W'($urandom_range(0, 255)));
					write_reg(CFG_DISPLAY_ON, CFG_DATA_W'($urandom_range(0, 255)));
					write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 255)));
				end
			endcase
			case (ph)
				1: begin tx_idle_pct <= 56; rx_stall_pct <= 0; end
				2: begin tx_idle_pct <= 0; rx_stall_pct <= 56; end
				3: begin tx_idle_pct <= 38; rx_stall_pct <= 38; end
				default: begin tx_idle_pct <= 0; rx_stall_pct <= 0; end
			endcase
			@(posedge clk);
			// hold the phase side off while requests keep coming, to back up the queue
			if (ph == 0) begin
				fork
					begin
						rx_hold <= 1'b1;
						repeat (LONG_HOLD) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 80) begin
					// framed transaction: start on the first, often a command, then mostly data, stop on the last
					len = $urandom_range(1, 4);
					for (int k = 0; k < len; k++)
						random_request(k == 0, k == len - 1, (k == 0) ? 50 : 12);
					sent += len;
				end else begin
					random_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 30);
					sent++;
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (pin_phase_q.size() != 0) begin
			$display("%0t: phases missing, expected %0d more, got none",
				$time, pin_phase_q.size());
			error_count++;
		end
		$display("Covered %0d requests and %0d register writes over %0d settings,",
			reqs_sent, reg_writes, RAND_PHASES + 1);
		$display("with %0d pin phases checked under mixed idling and a long output hold.",
			phases_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ldbs_pkg.sv
rtl/core/ldbs_if.sv
rtl/core/ldbs_front.sv
rtl/core/ldbs_fifo.sv
rtl/core/ldbs_back.sv
rtl/core/led_driver_two_wire_byte_serializer_top.sv
verif/tb_top.sv
